// ----- src/obff_pkg.sv -----
// ----------------------------------------------------------------------------
// obff_pkg
// Shared widths, types and register indexes of the oriented box force field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obff_pkg;

    localparam int ROT_W = 54;

    localparam logic [2:0] REG_CENTER   = 3'd0;
    localparam logic [2:0] REG_ROTATION = 3'd1;
    localparam logic [2:0] REG_HALF_EXT = 3'd2;
    localparam logic [2:0] REG_FORCE    = 3'd3;
    localparam logic [2:0] REG_GROUPS   = 3'd4;
    localparam logic [2:0] REG_MODE     = 3'd5;

    localparam logic [63:0] ROTATION_RESET = 64'd16384;

    typedef logic [2:0][16:0] v17_t;
    typedef logic [2:0][ROT_W-1:0] rot_vec_t;

    typedef struct packed {
        logic        pre;
        logic        active;
        logic [15:0] mass;
    } side_t;

    typedef struct packed {
        logic             wake_body;
        logic             applies;
        logic [2:0][31:0] frc;
    } res_t;

endpackage

`default_nettype wire

// ----- src/oriented_box_force_field_unit.sv -----
// ----------------------------------------------------------------------------
// oriented_box_force_field_unit
// Tests one body per transfer against one oriented box force field.
// ----------------------------------------------------------------------------
// Usage: the host writes the six field registers through cfg_we, cfg_index
// and cfg_wdata while no body is in flight, then streams bodies on the s_
// channel. Every body yields exactly one result transfer on the m_ channel,
// in order: the force to add in Q16.16 and the applies and wake flags.
// From input transfer to m_tvalid a body passes the input stage, six stages
// of the quaternion rotation datapath (one instance for the position, one
// for the force), four stages of inside test, rounding and mass scaling,
// and the output register. Throughput is one body per cycle while the skid
// entry is empty; the pipeline advances as a whole.
// When the receiver stalls, the output register holds its result and one
// more result goes into a skid entry; s_tready then drops until the receiver
// takes a transfer, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and returns the
// registers to their reset values: identity rotation, everything else zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oriented_box_force_field_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x, pos_y, pos_z, mass, body_membership, body_filter
    input  wire logic [95:0] s_tdata,
    // is_valid, is_dynamic, is_active
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // force_x, force_y, force_z
    output logic [95:0]      m_tdata,
    // applies, wake_body
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    localparam int ROT_LAT = 6;

    logic [47:0] center_reg;
    logic [63:0] rot_reg;
    logic [47:0] half_reg;
    logic [47:0] force_reg;
    logic [31:0] groups_reg;
    logic [2:0]  mode_reg;

    logic                  adv;
    logic                  a_valid_reg;
    obff_pkg::side_t       a_side_reg;
    obff_pkg::v17_t        a_rel_reg;
    obff_pkg::side_t       side_next;
    obff_pkg::v17_t        rel_next;
    obff_pkg::v17_t        u_conj;
    obff_pkg::v17_t        u_fwd;
    obff_pkg::v17_t        v_force;
    logic signed [16:0]    w_q;

    logic [ROT_LAT-1:0]    dv_reg;
    obff_pkg::side_t       dside_reg [ROT_LAT];

    obff_pkg::rot_vec_t    loc;
    obff_pkg::rot_vec_t    dirr;
    logic                  sc_valid;
    obff_pkg::res_t        sc_res;
    obff_pkg::res_t        m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            rot_reg    <= obff_pkg::ROTATION_RESET;
            half_reg   <= '0;
            force_reg  <= '0;
            groups_reg <= '0;
            mode_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                obff_pkg::REG_CENTER:   center_reg <= cfg_wdata[47:0];
                obff_pkg::REG_ROTATION: rot_reg    <= cfg_wdata;
                obff_pkg::REG_HALF_EXT: half_reg   <= cfg_wdata[47:0];
                obff_pkg::REG_FORCE:    force_reg  <= cfg_wdata[47:0];
                obff_pkg::REG_GROUPS:   groups_reg <= cfg_wdata[31:0];
                obff_pkg::REG_MODE:     mode_reg   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_q = 17'($signed(rot_reg[15:0]));
        for (int i = 0; i < 3; i++) begin
            rel_next[i] = 17'($signed(s_tdata[16*i +: 16])) -
                          17'($signed(center_reg[16*i +: 16]));
            u_fwd[i]    = 17'($signed(rot_reg[16*(i+1) +: 16]));
            u_conj[i]   = -17'($signed(rot_reg[16*(i+1) +: 16]));
            v_force[i]  = 17'($signed(force_reg[16*i +: 16]));
        end
        side_next.mass   = s_tdata[63:48];
        side_next.active = s_tuser[2];
        side_next.pre    = mode_reg[0] & s_tuser[0] & s_tuser[1] &
                           (s_tdata[63:48] != 16'd0) &
                           ((s_tdata[79:64] & groups_reg[15:0]) != 16'd0) &
                           ((groups_reg[31:16] & s_tdata[95:80]) != 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            dv_reg      <= '0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
            dv_reg      <= {dv_reg[ROT_LAT-2:0], a_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_side_reg   <= side_next;
            a_rel_reg    <= rel_next;
            dside_reg[0] <= a_side_reg;
            for (int k = 1; k < ROT_LAT; k++) begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    obff_rotate u_rot_local (
        .w_in  (w_q),
        .aclk  (aclk),
        .en    (adv),
        .u_in  (u_conj),
        .v_in  (a_rel_reg),
        .r_out (loc)
    );

    obff_rotate u_rot_force (
        .w_in  (w_q),
        .aclk  (aclk),
        .en    (adv),
        .u_in  (u_fwd),
        .v_in  (v_force),
        .r_out (dirr)
    );

    obff_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (dv_reg[ROT_LAT-1]),
        .in_side     (dside_reg[ROT_LAT-1]),
        .loc         (loc),
        .dirr        (dirr),
        .field_force (force_reg),
        .half        (half_reg),
        .mode        (mode_reg),
        .out_valid   (sc_valid),
        .out_res     (sc_res)
    );

    obff_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_res    (sc_res),
        .ready     (adv),
        .out_valid (m_tvalid),
        .out_res   (m_res),
        .out_ready (m_tready)
    );

    assign s_tready = adv;
    assign m_tdata  = m_res.frc;
    assign m_tuser  = {m_res.wake_body, m_res.applies};

endmodule

`default_nettype wire

// ----- src/obff_rotate.sv -----
// ----------------------------------------------------------------------------
// obff_rotate
// Six-stage quaternion rotation v + w*t + u x t with t = 2 (u x v), exact.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obff_rotate (
    input  wire logic                signed [16:0] w_in,
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire obff_pkg::v17_t      u_in,
    input  wire obff_pkg::v17_t      v_in,
    output obff_pkg::rot_vec_t       r_out
);

    localparam int RW = obff_pkg::ROT_W;
    localparam int A_IDX [3] = '{1, 2, 0};
    localparam int B_IDX [3] = '{2, 0, 1};

    logic signed [33:0]   pa1_reg [3];
    logic signed [33:0]   pb1_reg [3];
    logic signed [16:0]   w1_reg;
    logic signed [16:0]   u1_reg [3];
    logic signed [16:0]   v1_reg [3];

    logic signed [35:0]   t2_reg [3];
    logic signed [16:0]   w2_reg;
    logic signed [16:0]   u2_reg [3];
    logic signed [16:0]   v2_reg [3];

    logic signed [34:0]   wh3_reg [3];
    logic signed [35:0]   wl3_reg [3];
    logic signed [34:0]   ah3_reg [3];
    logic signed [35:0]   al3_reg [3];
    logic signed [34:0]   bh3_reg [3];
    logic signed [35:0]   bl3_reg [3];
    logic signed [16:0]   v3_reg [3];

    logic signed [RW-1:0] wt4_reg [3];
    logic signed [RW-1:0] ca4_reg [3];
    logic signed [RW-1:0] cb4_reg [3];
    logic signed [16:0]   v4_reg [3];

    logic signed [RW-1:0] s15_reg [3];
    logic signed [RW-1:0] s25_reg [3];

    logic signed [RW-1:0] r6_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg <= w_in;
            w2_reg <= w1_reg;
            for (int i = 0; i < 3; i++) begin
                pa1_reg[i] <= $signed(u_in[A_IDX[i]]) * $signed(v_in[B_IDX[i]]);
                pb1_reg[i] <= $signed(u_in[B_IDX[i]]) * $signed(v_in[A_IDX[i]]);
                u1_reg[i]  <= $signed(u_in[i]);
                v1_reg[i]  <= $signed(v_in[i]);

                t2_reg[i]  <= {35'(pa1_reg[i]) - 35'(pb1_reg[i]), 1'b0};
                u2_reg[i]  <= u1_reg[i];
                v2_reg[i]  <= v1_reg[i];

                wh3_reg[i] <= w2_reg * $signed(t2_reg[i][35:18]);
                wl3_reg[i] <= w2_reg * $signed({1'b0, t2_reg[i][17:0]});
                ah3_reg[i] <= u2_reg[A_IDX[i]] * $signed(t2_reg[B_IDX[i]][35:18]);
                al3_reg[i] <= u2_reg[A_IDX[i]] * $signed({1'b0, t2_reg[B_IDX[i]][17:0]});
                bh3_reg[i] <= u2_reg[B_IDX[i]] * $signed(t2_reg[A_IDX[i]][35:18]);
                bl3_reg[i] <= u2_reg[B_IDX[i]] * $signed({1'b0, t2_reg[A_IDX[i]][17:0]});
                v3_reg[i]  <= v2_reg[i];

                wt4_reg[i] <= (RW'(wh3_reg[i]) <<< 18) + RW'(wl3_reg[i]);
                ca4_reg[i] <= (RW'(ah3_reg[i]) <<< 18) + RW'(al3_reg[i]);
                cb4_reg[i] <= (RW'(bh3_reg[i]) <<< 18) + RW'(bl3_reg[i]);
                v4_reg[i]  <= v3_reg[i];

                s15_reg[i] <= (RW'(v4_reg[i]) <<< 28) + wt4_reg[i];
                s25_reg[i] <= ca4_reg[i] - cb4_reg[i];

                r6_reg[i]  <= s15_reg[i] + s25_reg[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r_out[i] = r6_reg[i];
        end
    end

endmodule

`default_nettype wire

// ----- src/obff_scale.sv -----
// ----------------------------------------------------------------------------
// obff_scale
// Inside test, direction select, rounding, mass scaling and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obff_scale (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire obff_pkg::side_t    in_side,
    input  wire obff_pkg::rot_vec_t loc,
    input  wire obff_pkg::rot_vec_t dirr,
    input  wire logic [47:0]        field_force,
    input  wire logic [47:0]        half,
    input  wire logic [2:0]         mode,
    output logic                    out_valid,
    output obff_pkg::res_t          out_res
);

    localparam int RW   = obff_pkg::ROT_W;
    localparam int D12W = RW - 11;
    localparam int D20W = RW - 19;
    localparam int PHW  = D12W - 20 + 17;
    localparam int PW   = PHW + 21;
    localparam int QW   = PW + 1 - 16;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    logic signed [RW:0]   lx_c [3];
    logic        [RW:0]   ax_c [3];
    logic signed [RW-1:0] dir_c [3];
    logic                 ins_c;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 app1_reg, act1_reg;
    logic [15:0]          mass1_reg, mass2_reg;
    logic signed [RW-1:0] dir1_reg [3];

    logic signed [RW:0]   s12_c [3];
    logic signed [RW:0]   s20_c [3];
    logic                 app2_reg, wake2_reg;
    logic signed [D12W-1:0] d12_2_reg [3];
    logic signed [D20W-1:0] d20_2_reg [3];

    logic                 app3_reg, wake3_reg;
    logic signed [PHW-1:0]  ph3_reg [3];
    logic signed [37:0]   pl3_reg [3];
    logic signed [D20W-1:0] d20_3_reg [3];

    logic                 app4_reg, wake4_reg;
    logic signed [PW-1:0] prod4_reg [3];
    logic signed [D20W-1:0] d20_4_reg [3];

    logic signed [PW:0]   sq_c [3];
    logic signed [QW-1:0] q_c [3];

    always_comb begin
        ins_c = 1'b1;
        for (int i = 0; i < 3; i++) begin
            lx_c[i] = (RW+1)'($signed(loc[i]));
            ax_c[i] = lx_c[i][RW] ? $unsigned(-lx_c[i]) : $unsigned(lx_c[i]);
            if (ax_c[i] > (RW+1)'({half[16*i +: 16], 28'd0})) begin
                ins_c = 1'b0;
            end
            dir_c[i] = mode[1] ? $signed(dirr[i])
                               : (RW'($signed(field_force[16*i +: 16])) <<< 28);
            s12_c[i] = (RW+1)'(dir1_reg[i]) + (RW+1)'(2048);
            s20_c[i] = (RW+1)'(dir1_reg[i]) + (RW+1)'(524288);
            sq_c[i]  = (PW+1)'(prod4_reg[i]) + (PW+1)'(32768);
            q_c[i]   = $signed(sq_c[i][PW:16]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            app1_reg  <= in_side.pre & ins_c;
            act1_reg  <= in_side.active;
            mass1_reg <= in_side.mass;

            app2_reg  <= app1_reg;
            wake2_reg <= app1_reg & ~act1_reg &
                         ((dir1_reg[0] != '0) | (dir1_reg[1] != '0) | (dir1_reg[2] != '0));
            mass2_reg <= mass1_reg;

            app3_reg  <= app2_reg;
            wake3_reg <= wake2_reg;

            app4_reg  <= app3_reg;
            wake4_reg <= wake3_reg;

            for (int i = 0; i < 3; i++) begin
                dir1_reg[i]  <= dir_c[i];

                d12_2_reg[i] <= $signed(s12_c[i][RW:12]);
                d20_2_reg[i] <= $signed(s20_c[i][RW:20]);

                ph3_reg[i]   <= $signed(d12_2_reg[i][D12W-1:20]) *
                                $signed({1'b0, mass2_reg});
                pl3_reg[i]   <= $signed({1'b0, d12_2_reg[i][19:0]}) *
                                $signed({1'b0, mass2_reg});
                d20_3_reg[i] <= d20_2_reg[i];

                prod4_reg[i] <= (PW'(ph3_reg[i]) <<< 20) + PW'(pl3_reg[i]);
                d20_4_reg[i] <= d20_3_reg[i];
            end
        end
    end

    always_comb begin
        out_valid         = v4_reg;
        out_res.applies   = app4_reg;
        out_res.wake_body = wake4_reg;
        for (int i = 0; i < 3; i++) begin
            if (!app4_reg) begin
                out_res.frc[i] = '0;
            end else if (mode[2]) begin
                out_res.frc[i] = sat32(64'(q_c[i]));
            end else begin
                out_res.frc[i] = sat32(64'(d20_4_reg[i]));
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/obff_out_buf.sv -----
// ----------------------------------------------------------------------------
// obff_out_buf
// Output register with a skid entry; its ready advances the whole pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obff_out_buf (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire obff_pkg::res_t  in_res,
    output logic                 ready,
    output logic                 out_valid,
    output obff_pkg::res_t       out_res,
    input  wire logic            out_ready
);

    logic           main_valid_reg;
    logic           skid_valid_reg;
    obff_pkg::res_t main_reg;
    obff_pkg::res_t skid_reg;
    logic           push;
    logic           pop;

    assign ready     = ~skid_valid_reg;
    assign push      = ready & in_valid;
    assign pop       = main_valid_reg & out_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= in_res;
            end else begin
                main_reg <= in_res;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/obff_checker.sv -----
// ----------------------------------------------------------------------------
// obff_checker
// Port-level checks of the force field unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obff_port_checks (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A body is only woken when the field acts on it.
    a_wake_applies: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("wake without applies");

    // A field that does not act gives no force.
    a_zero_force: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 96'd0)
        else $error("force without applies");

    // Input back-pressure only follows a stalled result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("s_tready low without output stall");

endmodule

bind oriented_box_force_field_unit obff_port_checks u_obff_checker (.*);

`default_nettype wire

// ----- tb/obff_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// obff_tb_pkg
// Mode and body flag masks shared by the force field testbench and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obff_tb_pkg;

    localparam logic [2:0] MODE_ENABLE = 3'b001;
    localparam logic [2:0] MODE_LOCAL  = 3'b010;
    localparam logic [2:0] MODE_ACCEL  = 3'b100;

    localparam logic [2:0] BODY_VALID   = 3'b001;
    localparam logic [2:0] BODY_DYNAMIC = 3'b010;
    localparam logic [2:0] BODY_ACTIVE  = 3'b100;

endpackage

// ----- tb/obff_checker.sv -----
// ----------------------------------------------------------------------------
// obff_checker
// Watches the body and force channels of the oriented box force field unit,
// keeps its own copy of the field registers, computes the force each body
// transfer must produce and compares every result transfer against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obff_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    import obff_pkg::*;
    import obff_tb_pkg::*;

    typedef logic [2:0][63:0] lvec_t;

    localparam longint ONE_Q28 = 64'sd268435456;
    localparam longint SAT_HI  = 64'sd2147483647;
    localparam longint SAT_LO  = -64'sd2147483648;

    logic [47:0] center_r;
    logic [63:0] rot_r;
    logic [47:0] half_r;
    logic [47:0] force_r;
    logic [31:0] groups_r;
    logic [2:0]  mode_r;

    res_t expected_forces[$];

    function automatic lvec_t quat_turn(input longint w, input lvec_t u, input lvec_t v);
        longint ux, uy, uz, vx, vy, vz, tx, ty, tz;
        lvec_t r;
        ux = $signed(u[0]);
        uy = $signed(u[1]);
        uz = $signed(u[2]);
        vx = $signed(v[0]);
        vy = $signed(v[1]);
        vz = $signed(v[2]);
        tx = 2 * (uy * vz - uz * vy);
        ty = 2 * (uz * vx - ux * vz);
        tz = 2 * (ux * vy - uy * vx);
        r[0] = vx * ONE_Q28 + w * tx + (uy * tz - uz * ty);
        r[1] = vy * ONE_Q28 + w * ty + (uz * tx - ux * tz);
        r[2] = vz * ONE_Q28 + w * tz + (ux * ty - uy * tx);
        return r;
    endfunction

    function automatic longint round_half_up(input longint x, input int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic logic [31:0] sat32(input longint x);
        if (x > SAT_HI) begin
            return 32'h7FFF_FFFF;
        end
        if (x < SAT_LO) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic res_t field_response(input logic [95:0] body, input logic [2:0] flags);
        lvec_t rel, spin, spin_conj, fvec, loc, dir;
        longint w, lim, mag, lane_u;
        logic [15:0] mass, bmem, bfil, fmem, ffil;
        logic hit;
        res_t r;
        mass = body[63:48];
        bmem = body[79:64];
        bfil = body[95:80];
        fmem = groups_r[31:16];
        ffil = groups_r[15:0];
        w = longint'($signed(rot_r[15:0]));
        for (int i = 0; i < 3; i++) begin
            lane_u = longint'($signed(rot_r[16 * (i + 1) +: 16]));
            spin[i] = lane_u;
            spin_conj[i] = -lane_u;
            rel[i] = longint'($signed(body[16 * i +: 16]))
                     - longint'($signed(center_r[16 * i +: 16]));
            fvec[i] = longint'($signed(force_r[16 * i +: 16]));
        end

        hit = ((mode_r & MODE_ENABLE) != 0) && ((flags & BODY_VALID) != 0)
              && ((flags & BODY_DYNAMIC) != 0) && (mass != 0)
              && ((bmem & ffil) != 0) && ((fmem & bfil) != 0);

        loc = quat_turn(w, spin_conj, rel);
        for (int i = 0; i < 3; i++) begin
            lim = longint'({48'd0, half_r[16 * i +: 16]}) * ONE_Q28;
            mag = $signed(loc[i]);
            if (mag < 0) begin
                mag = -mag;
            end
            if (mag > lim) begin
                hit = 1'b0;
            end
        end

        r = '0;
        if (hit) begin
            if ((mode_r & MODE_LOCAL) != 0) begin
                dir = quat_turn(w, spin, fvec);
            end else begin
                for (int i = 0; i < 3; i++) begin
                    dir[i] = longint'($signed(fvec[i])) * ONE_Q28;
                end
            end
            for (int i = 0; i < 3; i++) begin
                if ((mode_r & MODE_ACCEL) != 0) begin
                    r.frc[i] = sat32(round_half_up(round_half_up($signed(dir[i]), 12)
                                     * longint'({48'd0, mass}), 16));
                end else begin
                    r.frc[i] = sat32(round_half_up($signed(dir[i]), 20));
                end
            end
            r.wake_body = ((flags & BODY_ACTIVE) == 0) && (dir != '0);
        end
        r.applies = hit;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        res_t got;
        res_t want;
        int bad;
        bad = 0;
        if (!aresetn) begin
            center_r <= '0;
            rot_r    <= ROTATION_RESET;
            half_r   <= '0;
            force_r  <= '0;
            groups_r <= '0;
            mode_r   <= '0;
            expected_forces.delete();
            mismatches <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CENTER:   center_r <= cfg_wdata[47:0];
                    REG_ROTATION: rot_r    <= cfg_wdata;
                    REG_HALF_EXT: half_r   <= cfg_wdata[47:0];
                    REG_FORCE:    force_r  <= cfg_wdata[47:0];
                    REG_GROUPS:   groups_r <= cfg_wdata[31:0];
                    REG_MODE:     mode_r   <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_forces.insert(expected_forces.size(),
                                       field_response(s_tdata, s_tuser));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (expected_forces.size() == 0) begin
                    $error("result transfer with no body outstanding: %h", got);
                    bad++;
                end else begin
                    want = expected_forces.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.frc[i] !== want.frc[i]) begin
                            $error("force_%s: expected %0d, got %0d",
                                   (i == 0) ? "x" : (i == 1) ? "y" : "z",
                                   $signed(want.frc[i]), $signed(got.frc[i]));
                            bad++;
                        end
                    end
                    if (got.applies !== want.applies) begin
                        $error("applies: expected %0b, got %0b", want.applies, got.applies);
                        bad++;
                    end
                    if (got.wake_body !== want.wake_body) begin
                        $error("wake_body: expected %0b, got %0b",
                               want.wake_body, got.wake_body);
                        bad++;
                    end
                end
            end
            mismatches <= mismatches + bad;
        end
        outstanding <= expected_forces.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives bodies and field settings into the oriented box force field unit.
// A short directed sequence covers the field extremes, every mode, the
// boundary, group and flag rejections and the wake rules; then random field
// settings each carry a batch of bodies, mostly clustered around the box, with
// random idle bursts on both channels. The checker does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import obff_pkg::*;
    import obff_tb_pkg::*;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [2:0] FLAGS_AWAKE  = BODY_VALID | BODY_DYNAMIC | BODY_ACTIVE;
    localparam logic [2:0] FLAGS_ASLEEP = BODY_VALID | BODY_DYNAMIC;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_PHASES  = 14;
    localparam int CALM_PHASES    = 2;
    localparam int BODIES_PER_PHASE = 125;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [95:0] m_tdata;
    wire  [1:0]  m_tuser;
    int          mismatches;
    int          outstanding;

    logic [47:0] cur_center = '0;
    logic [47:0] cur_half = '0;
    logic [31:0] cur_groups = '0;
    bit          calm = 1'b0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          sink_stall = 0;
    int          quiet_cycles = 0;

    oriented_box_force_field_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    obff_checker force_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall <= 0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (sink_stall != 0) begin
            m_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            m_tready <= 1'b0;
            sink_stall <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [95:0] pack_body(input logic [15:0] px, input logic [15:0] py,
                                              input logic [15:0] pz, input logic [15:0] mass,
                                              input logic [15:0] bmem, input logic [15:0] bfil);
        return {bfil, bmem, mass, pz, py, px};
    endfunction

    function automatic int idle_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [63:0] quat_preset(input int k);
        case (k)
            0: return {16'd0, 16'd0, 16'd0, 16'd16384};
            1: return {16'd11585, 16'd0, 16'd0, 16'd11585};
            2: return {16'd0, 16'd0, 16'd11585, 16'd11585};
            3: return {16'd0, 16'(-11585), 16'd0, 16'd11585};
            4: return {16'd0, 16'd0, 16'd16384, 16'd0};
            5: return {16'd8192, 16'd8192, 16'd8192, 16'd8192};
            6: return {16'(-8192), 16'd8192, 16'(-8192), 16'd8192};
            default: return {16'd0, 16'd0, 16'd0, 16'(-16384)};
        endcase
    endfunction

    task automatic send_body(input logic [95:0] body, input logic [2:0] flags);
        if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= body;
        s_tuser <= flags;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_field(input logic [47:0] center, input logic [63:0] rot,
                              input logic [47:0] half, input logic [47:0] force_v,
                              input logic [31:0] groups, input logic [2:0] mode);
        settle();
        cfg_write(REG_CENTER, {16'($urandom), center});
        cfg_write(REG_ROTATION, rot);
        cfg_write(REG_HALF_EXT, {16'($urandom), half});
        cfg_write(REG_FORCE, {16'($urandom), force_v});
        cfg_write(REG_GROUPS, {$urandom, groups});
        cfg_write(REG_MODE, {61'($urandom), mode});
        cfg_we <= 1'b0;
        cur_center = center;
        cur_half = half;
        cur_groups = groups;
        @(posedge aclk);
    endtask

    task automatic random_field();
        logic [47:0] center, half, force_v;
        logic [63:0] rot;
        logic [31:0] groups;
        logic [2:0] mode;
        int pick;
        for (int i = 0; i < 3; i++) begin
            center[16 * i +: 16] = ($urandom_range(0, 9) < 7)
                ? 16'($urandom_range(0, 16'h4000)) - 16'h2000 : 16'($urandom);
            pick = $urandom_range(0, 9);
            half[16 * i +: 16] = (pick < 2) ? 16'($urandom)
                : (pick == 9) ? 16'hFFFF : 16'($urandom_range(0, 16'h0800));
            force_v[16 * i +: 16] = 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0, 1: rot = quat_preset($urandom_range(0, 7));
            2: rot = {16'(int'($urandom_range(0, 6000)) - 3000),
                      16'(int'($urandom_range(0, 6000)) - 3000),
                      16'(int'($urandom_range(0, 6000)) - 3000),
                      16'(16384 - int'($urandom_range(0, 600)))};
            default: rot = {$urandom, $urandom};
        endcase
        groups = ($urandom_range(0, 4) != 0)
            ? $urandom | (32'd1 << $urandom_range(0, 15)) | (32'd1 << $urandom_range(16, 31))
            : $urandom;
        mode = ($urandom_range(0, 3) != 0) ? (3'($urandom) | MODE_ENABLE) : 3'($urandom);
        load_field(center, rot, half, force_v, groups, mode);
        src_idle_pct = idle_rate();
        sink_idle_pct = idle_rate();
    endtask

    task automatic send_random_body();
        logic [2:0][15:0] pos;
        logic [15:0] mass, bmem, bfil;
        logic [2:0] flags;
        int span, pick;
        if ($urandom_range(0, 99) < 15) begin
            send_body({$urandom, $urandom, $urandom}, 3'($urandom));
        end else begin
            for (int i = 0; i < 3; i++) begin
                span = int'(cur_half[16 * i +: 16]);
                span = span + span / 4 + 1;
                pos[i] = cur_center[16 * i +: 16]
                         + 16'(int'($urandom_range(0, 2 * span)) - span);
            end
            pick = $urandom_range(0, 99);
            mass = (pick < 8) ? 16'h0000 : (pick < 13) ? 16'hFFFF : 16'($urandom);
            bmem = 16'($urandom);
            bfil = 16'($urandom);
            if ($urandom_range(0, 99) < 85) begin
                bmem = bmem | (cur_groups[15:0] & 16'($urandom));
                bfil = bfil | (cur_groups[31:16] & 16'($urandom));
            end
            flags = ($urandom_range(0, 99) < 85)
                ? (FLAGS_ASLEEP | ($urandom_range(0, 1) ? BODY_ACTIVE : 3'b000))
                : 3'($urandom);
            send_body(pack_body(pos[0], pos[1], pos[2], mass, bmem, bfil), flags);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: the field is disabled, so nothing applies.
        send_body(pack_body(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                  FLAGS_AWAKE);
        send_body(pack_body(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0100, 16'hFFFF, 16'hFFFF),
                  FLAGS_ASLEEP);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 16'hFFFF),
                  FLAGS_AWAKE);

        // Unit box at the origin; writes to the unused indexes must change nothing.
        load_field(48'h0, ROTATION_RESET, {3{16'h0100}}, {16'h0001, 16'h8000, 16'h7FFF},
                   32'hFFFF_FFFF, MODE_ENABLE);
        cfg_write(REG_SPARE_LO, '1);
        cfg_write(REG_SPARE_HI, '1);
        cfg_we <= 1'b0;
        @(posedge aclk);
        send_body(pack_body(16'h0100, 16'hFF00, 16'h0100, 16'h0100, 16'hFFFF, 16'hFFFF),
                  FLAGS_AWAKE);
        send_body(pack_body(16'h0101, 16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 16'hFFFF),
                  FLAGS_AWAKE);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 16'hFFFF),
                  FLAGS_ASLEEP);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF),
                  FLAGS_ASLEEP);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 16'hFFFF),
                  BODY_VALID | BODY_ACTIVE);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 16'hFFFF),
                  BODY_DYNAMIC | BODY_ACTIVE);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'hFFFF),
                  FLAGS_AWAKE);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'hFFFF, 16'h0000),
                  FLAGS_AWAKE);

        // Unnormalized rotation with largest box, force and mass: saturation.
        load_field({3{16'h8000}}, 64'h8000_8000_8000_8000, {3{16'hFFFF}},
                   {16'h7FFF, 16'h8000, 16'h7FFF}, 32'h0001_0001,
                   MODE_ENABLE | MODE_LOCAL | MODE_ACCEL);
        send_body(pack_body(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001, 16'h0001),
                  FLAGS_ASLEEP);
        send_body(pack_body(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0001),
                  FLAGS_AWAKE);
        send_body(pack_body(16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'h0001, 16'h0001),
                  FLAGS_ASLEEP);

        load_field({3{16'h8000}}, 64'h8000_8000_8000_8000, {3{16'hFFFF}},
                   {16'h7FFF, 16'h8000, 16'h7FFF}, 32'hFFFF_FFFF, MODE_ENABLE | MODE_LOCAL);
        send_body(pack_body(16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF),
                  FLAGS_ASLEEP);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF),
                  FLAGS_AWAKE);

        // A zero field vector applies but never wakes a sleeping body.
        load_field(48'h0, ROTATION_RESET, {3{16'h0100}}, 48'h0, 32'hFFFF_FFFF,
                   MODE_ENABLE | MODE_ACCEL);
        send_body(pack_body(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                  FLAGS_ASLEEP);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_field();
            if (phase >= RANDOM_PHASES - CALM_PHASES) begin
                calm = 1'b1;
            end
            repeat (BODIES_PER_PHASE) send_random_body();
        end

        settle();
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
